[rtl/cpfv_pkg.sv]
// package: shared types, constants and helper functions of the cpf validator
`default_nettype none
package cpfv_pkg;

   localparam logic [3:0] CPF_LEN   = 4'd14;
   localparam logic [3:0] POS_MAX   = 4'd15;
   localparam logic [3:0] POS_DOT_A = 4'd3;
   localparam logic [3:0] POS_DOT_B = 4'd7;
   localparam logic [3:0] POS_DASH  = 4'd11;
   localparam logic [3:0] POS_LAST  = 4'd13;
   localparam logic [3:0] MOD       = 4'd11;
   localparam logic [3:0] W1_TOP    = 4'd10;
   localparam logic [3:0] W2_TOP    = 4'd11;
   localparam logic [3:0] K_TENTH   = 4'd9;
   localparam logic [3:0] K_SEP     = 4'd15;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_DASH   = 8'h2D;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;

   typedef enum logic [2:0] {
      ERR_NONE   = 3'd0,
      ERR_LENGTH = 3'd1,
      ERR_DOT    = 3'd2,
      ERR_DASH   = 3'd3,
      ERR_DIGIT  = 3'd4,
      ERR_CHECK  = 3'd5
   } err_type;

   typedef struct packed {
      logic       enable;
      logic       last;
      logic [7:0] char_code;
   } step_type;

   typedef struct packed {
      logic    is_valid;
      err_type error_code;
   } verdict_type;

   // reduce a value below 128 mod 11 by binary long division
   function automatic logic [3:0] mod11(input logic [6:0] v);
      logic [6:0] r;
      r = v;
      if (r >= 7'd88) r = r - 7'd88;
      if (r >= 7'd44) r = r - 7'd44;
      if (r >= 7'd22) r = r - 7'd22;
      if (r >= 7'd11) r = r - 7'd11;
      return r[3:0];
   endfunction

   function automatic logic [3:0] check_from_rem(input logic [3:0] r);
      return (r < 4'd2) ? 4'd0 : 4'(MOD - r);
   endfunction

   // digit index of a position, separators map to K_SEP
   function automatic logic [3:0] digit_index(input logic [3:0] pos);
      logic [3:0] k;
      unique case (pos) inside
         4'd0, 4'd1, 4'd2:            k = pos;
         4'd4, 4'd5, 4'd6:            k = 4'(pos - 4'd1);
         4'd8, 4'd9, 4'd10:           k = 4'(pos - 4'd2);
         4'd12, 4'd13, 4'd14, 4'd15:  k = 4'(pos - 4'd3);
         default:                     k = K_SEP;
      endcase
      return k;
   endfunction

endpackage
`default_nettype wire

[rtl/cpf_format_and_check_digit_validator_unit.sv]
// top level: input register, running checker and result register of the cpf validator
//
// Takes one character of a CPF string (ddd.ddd.ddd-dd) per item, the last one flagged
// by req_end_of_string, and gives one result item per string with is_valid and an
// error code (0 ok, 1 length, 2 dots, 3 dash, 4 non-digit, 5 check digits). One item
// is accepted every cycle unless input stalls; a result is written to the result register
// when its final character leaves the input register: the combinational mod-11 update
// feeds the result register. Input stalls only when a final character waits for a result
// register still held by rsp_stall; no clearing pass is needed after reset.
`default_nettype none
module cpf_format_and_check_digit_validator_unit (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output      logic       req_stall,
   input  wire logic [7:0] req_char_code,
   input  wire logic       req_end_of_string,
   output      logic       rsp_valid,
   input  wire logic       rsp_stall,
   output      logic       rsp_is_valid,
   output      logic [2:0] rsp_error_code
);

   logic       s1_valid_ff;
   logic [7:0] s1_char_ff;
   logic       s1_last_ff;
   logic       s1_adv;
   logic       rsp_valid_ff;
   logic       rsp_is_valid_ff;
   logic [2:0] rsp_error_ff;

   cpfv_pkg::step_type    step;
   cpfv_pkg::verdict_type verdict;

   assign s1_adv    = !(s1_last_ff && rsp_valid_ff && rsp_stall);
   assign req_stall = s1_valid_ff && !s1_adv;

   assign step.enable    = s1_valid_ff && s1_adv;
   assign step.last      = s1_last_ff;
   assign step.char_code = s1_char_ff;

   cpfv_accum u_accum (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .verdict (verdict)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         s1_char_ff <= req_char_code;
         s1_last_ff <= req_end_of_string;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step.enable && step.last) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step.enable && step.last) begin
         rsp_is_valid_ff <= verdict.is_valid;
         rsp_error_ff    <= verdict.error_code;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_is_valid   = rsp_is_valid_ff;
   assign rsp_error_code = rsp_error_ff;

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid_ff && rsp_stall && s1_last_ff)
      else $error("input stalled without a blocked result");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      step.enable && step.last |-> !rsp_valid_ff || !rsp_stall)
      else $error("result register overwritten while held");

   a_item_kept: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && req_stall |=> s1_valid_ff && $stable(s1_char_ff))
      else $error("waiting item lost from input register");

endmodule
`default_nettype wire

[rtl/cpfv_accum.sv]
// running position, format flags and mod-11 sums, with the end-of-string verdict
`default_nettype none
module cpfv_accum (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire cpfv_pkg::step_type   step,
   output cpfv_pkg::verdict_type     verdict
);

   logic [3:0] pos_ff, pos_in;
   logic [3:0] sum1_ff, sum1_in;
   logic [3:0] sum2_ff, sum2_in;
   logic [3:0] tenth_ff, tenth_in;
   logic       dot_miss_ff, dot_miss_in;
   logic       dash_miss_ff, dash_miss_in;
   logic       non_digit_ff, non_digit_in;

   logic       is_dig;
   logic [7:0] char_off;
   logic [3:0] d;
   logic [3:0] k;
   logic       in_range;
   logic       dot_pos;
   logic       dash_pos;
   logic [3:0] w1;
   logic [3:0] w2;
   logic [7:0] prod1;
   logic [7:0] prod2;
   logic [3:0] upd1;
   logic [3:0] upd2;
   logic [3:0] last_digit;
   logic [3:0] chk_x;
   logic [3:0] chk_t;
   logic [3:0] chk_y;
   cpfv_pkg::err_type err;

   assign is_dig   = (step.char_code >= cpfv_pkg::CH_ZERO) &&
                     (step.char_code <= cpfv_pkg::CH_NINE);
   assign char_off = step.char_code - cpfv_pkg::CH_ZERO;
   assign d        = is_dig ? char_off[3:0] : 4'd0;
   assign k        = cpfv_pkg::digit_index(pos_ff);
   assign in_range = pos_ff < cpfv_pkg::CPF_LEN;
   assign dot_pos  = (pos_ff == cpfv_pkg::POS_DOT_A) || (pos_ff == cpfv_pkg::POS_DOT_B);
   assign dash_pos = pos_ff == cpfv_pkg::POS_DASH;
   assign w1       = 4'(cpfv_pkg::W1_TOP - k);
   assign w2       = 4'(cpfv_pkg::W2_TOP - k);
   assign prod1    = {4'd0, d} * {4'd0, w1};
   assign prod2    = {4'd0, d} * {4'd0, w2};
   assign upd1     = cpfv_pkg::mod11(7'({3'd0, sum1_ff} + prod1[6:0]));
   assign upd2     = cpfv_pkg::mod11(7'({3'd0, sum2_ff} + prod2[6:0]));

   always_comb begin
      sum1_in      = sum1_ff;
      sum2_in      = sum2_ff;
      tenth_in     = tenth_ff;
      dot_miss_in  = dot_miss_ff;
      dash_miss_in = dash_miss_ff;
      non_digit_in = non_digit_ff;
      last_digit   = 4'd0;
      if (in_range) begin
         if (dot_pos) begin
            if (step.char_code != cpfv_pkg::CH_DOT) dot_miss_in = 1'b1;
         end else if (dash_pos) begin
            if (step.char_code != cpfv_pkg::CH_DASH) dash_miss_in = 1'b1;
         end else if (!is_dig) begin
            non_digit_in = 1'b1;
         end else if (k < cpfv_pkg::K_TENTH) begin
            sum1_in = upd1;
            sum2_in = upd2;
         end else if (k == cpfv_pkg::K_TENTH) begin
            tenth_in = d;
         end else begin
            last_digit = d;
         end
      end
      pos_in = (pos_ff == cpfv_pkg::POS_MAX) ? pos_ff : 4'(pos_ff + 4'd1);
   end

   assign chk_x = cpfv_pkg::check_from_rem(sum1_ff);
   assign chk_t = cpfv_pkg::mod11({3'd0, sum2_ff} + {2'd0, chk_x, 1'b0});
   assign chk_y = cpfv_pkg::check_from_rem(chk_t);

   always_comb begin
      if (pos_ff != cpfv_pkg::POS_LAST) begin
         err = cpfv_pkg::ERR_LENGTH;
      end else if (dot_miss_in) begin
         err = cpfv_pkg::ERR_DOT;
      end else if (dash_miss_in) begin
         err = cpfv_pkg::ERR_DASH;
      end else if (non_digit_in) begin
         err = cpfv_pkg::ERR_DIGIT;
      end else if ((tenth_ff == chk_x) && (last_digit == chk_y)) begin
         err = cpfv_pkg::ERR_NONE;
      end else begin
         err = cpfv_pkg::ERR_CHECK;
      end
      verdict.error_code = err;
      verdict.is_valid   = err == cpfv_pkg::ERR_NONE;
   end

   always_ff @(posedge clock) begin
      if (reset || (step.enable && step.last)) begin
         pos_ff       <= 4'd0;
         sum1_ff      <= 4'd0;
         sum2_ff      <= 4'd0;
         tenth_ff     <= 4'd0;
         dot_miss_ff  <= 1'b0;
         dash_miss_ff <= 1'b0;
         non_digit_ff <= 1'b0;
      end else if (step.enable) begin
         pos_ff       <= pos_in;
         sum1_ff      <= sum1_in;
         sum2_ff      <= sum2_in;
         tenth_ff     <= tenth_in;
         dot_miss_ff  <= dot_miss_in;
         dash_miss_ff <= dash_miss_in;
         non_digit_ff <= non_digit_in;
      end
   end

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      step.enable && step.last |=> (pos_ff == 4'd0) && (sum1_ff == 4'd0) &&
         (sum2_ff == 4'd0) && !dot_miss_ff && !dash_miss_ff && !non_digit_ff)
      else $error("state not cleared after end of string");

   a_pos_advance: assert property (@(posedge clock) disable iff (reset)
      step.enable && !step.last && (pos_ff != cpfv_pkg::POS_MAX)
         |=> pos_ff == 4'($past(pos_ff) + 4'd1))
      else $error("position did not advance");

   a_sums_reduced: assert property (@(posedge clock) disable iff (reset)
      (sum1_ff < cpfv_pkg::MOD) && (sum2_ff < cpfv_pkg::MOD))
      else $error("running sum not reduced mod 11");

endmodule
`default_nettype wire

[verif/cpf_format_and_check_digit_validator_unit_tb.sv]
// testbench: cpf string validator driven with directed and random strings, checked per item
`default_nettype none
module cpf_format_and_check_digit_validator_unit_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int FLAG_DOT   = 0;
   localparam int FLAG_DASH  = 1;
   localparam int FLAG_DIGIT = 2;
   localparam int RANDOM_ITEMS = 2000;
   localparam int HOLD_AFTER   = 20;
   localparam int HOLD_CYCLES  = 300;
   localparam int TAIL_CYCLES  = 10;

   typedef struct packed {
      logic [7:0]        ch;
      logic              last;
      logic              typed;
      cpfv_pkg::err_type verdict;
   } char_item_type;

   typedef struct {
      string             text;
      bit                typed;
      cpfv_pkg::err_type verdict;
   } dir_row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_char_code = 8'd0;
   logic       req_end_of_string = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_is_valid;
   logic [2:0] rsp_error_code;

   char_item_type         char_feed[$];
   char_item_type         offered = '0;
   cpfv_pkg::verdict_type pending_verdicts[$];
   int                    feed_total;
   int                    items_accepted = 0;
   int                    results_seen = 0;
   bit                    failed = 1'b0;

   // tracked string state
   logic [3:0] trk_pos = '0;
   logic [3:0] trk_sum1 = '0;
   logic [3:0] trk_sum2 = '0;
   logic [3:0] trk_tenth = '0;
   logic [2:0] trk_flags = '0;

   cpf_format_and_check_digit_validator_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_char_code     (req_char_code),
      .req_end_of_string (req_end_of_string),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_is_valid      (rsp_is_valid),
      .rsp_error_code    (rsp_error_code)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int unsigned check_of(input int unsigned r);
      return (r < 2) ? 0 : cpfv_pkg::MOD - r;
   endfunction

   // advance the tracked state by one character, returns 1 when a verdict is due
   function automatic bit cpf_scan_char(input logic [7:0] ch, input logic last,
                                        output cpfv_pkg::err_type code);
      int unsigned d, k, final_digit, x, y;
      bit digit;
      digit = (ch >= cpfv_pkg::CH_ZERO) && (ch <= cpfv_pkg::CH_NINE);
      d = digit ? int'(ch - cpfv_pkg::CH_ZERO) : 0;
      final_digit = 0;
      code = cpfv_pkg::ERR_NONE;
      if (trk_pos < cpfv_pkg::CPF_LEN) begin
         if (trk_pos == cpfv_pkg::POS_DOT_A || trk_pos == cpfv_pkg::POS_DOT_B) begin
            if (ch != cpfv_pkg::CH_DOT) trk_flags[FLAG_DOT] = 1'b1;
         end else if (trk_pos == cpfv_pkg::POS_DASH) begin
            if (ch != cpfv_pkg::CH_DASH) trk_flags[FLAG_DASH] = 1'b1;
         end else if (!digit) begin
            trk_flags[FLAG_DIGIT] = 1'b1;
         end else begin
            if (trk_pos > cpfv_pkg::POS_DASH) k = trk_pos - 3;
            else if (trk_pos > cpfv_pkg::POS_DOT_B) k = trk_pos - 2;
            else if (trk_pos > cpfv_pkg::POS_DOT_A) k = trk_pos - 1;
            else k = trk_pos;
            if (k < cpfv_pkg::K_TENTH) begin
               trk_sum1 = 4'((trk_sum1 + d * (cpfv_pkg::W1_TOP - k)) % cpfv_pkg::MOD);
               trk_sum2 = 4'((trk_sum2 + d * (cpfv_pkg::W2_TOP - k)) % cpfv_pkg::MOD);
            end else if (k == cpfv_pkg::K_TENTH) begin
               trk_tenth = 4'(d);
            end else begin
               final_digit = d;
            end
         end
      end
      if (!last) begin
         if (trk_pos != cpfv_pkg::POS_MAX) trk_pos = trk_pos + 4'd1;
         return 1'b0;
      end
      if (trk_pos != cpfv_pkg::POS_LAST) code = cpfv_pkg::ERR_LENGTH;
      else if (trk_flags[FLAG_DOT]) code = cpfv_pkg::ERR_DOT;
      else if (trk_flags[FLAG_DASH]) code = cpfv_pkg::ERR_DASH;
      else if (trk_flags[FLAG_DIGIT]) code = cpfv_pkg::ERR_DIGIT;
      else begin
         x = check_of(trk_sum1);
         y = check_of((trk_sum2 + 2 * x) % cpfv_pkg::MOD);
         code = (trk_tenth == x && final_digit == y) ? cpfv_pkg::ERR_NONE
                                                     : cpfv_pkg::ERR_CHECK;
      end
      trk_pos = '0;
      trk_sum1 = '0;
      trk_sum2 = '0;
      trk_tenth = '0;
      trk_flags = '0;
      return 1'b1;
   endfunction

   task automatic feed_string(ref logic [7:0] txt[$], input bit typed,
                              input cpfv_pkg::err_type verdict);
      char_item_type it;
      for (int i = 0; i < txt.size(); i++) begin
         it.ch = txt[i];
         it.last = (i == txt.size() - 1);
         it.typed = typed;
         it.verdict = verdict;
         char_feed.push_back(it);
      end
   endtask

   // well formed cpf with correct check digits
   task automatic make_cpf(ref logic [7:0] txt[$]);
      int unsigned dig[11];
      int unsigned s1, s2, n;
      s1 = 0;
      s2 = 0;
      for (int i = 0; i < 9; i++) begin
         dig[i] = $urandom_range(0, 9);
         s1 += dig[i] * (cpfv_pkg::W1_TOP - i);
         s2 += dig[i] * (cpfv_pkg::W2_TOP - i);
      end
      dig[9] = check_of(s1 % cpfv_pkg::MOD);
      dig[10] = check_of((s2 + 2 * dig[9]) % cpfv_pkg::MOD);
      txt.delete();
      n = 0;
      for (int p = 0; p < cpfv_pkg::CPF_LEN; p++) begin
         if (p == cpfv_pkg::POS_DOT_A || p == cpfv_pkg::POS_DOT_B) begin
            txt.push_back(cpfv_pkg::CH_DOT);
         end else if (p == cpfv_pkg::POS_DASH) begin
            txt.push_back(cpfv_pkg::CH_DASH);
         end else begin
            txt.push_back(8'(cpfv_pkg::CH_ZERO + dig[n]));
            n++;
         end
      end
   endtask

   task automatic make_random_string(ref logic [7:0] txt[$]);
      int kind, len, p, sel;
      kind = $urandom_range(0, 99);
      make_cpf(txt);
      if (kind < 35) begin
      end else if (kind < 50) begin
         txt[12] = 8'(cpfv_pkg::CH_ZERO + $urandom_range(0, 9));
         txt[13] = 8'(cpfv_pkg::CH_ZERO + $urandom_range(0, 9));
      end else if (kind < 72) begin
         repeat ($urandom_range(1, 2)) begin
            p = $urandom_range(0, cpfv_pkg::CPF_LEN - 1);
            sel = $urandom_range(0, 3);
            case (sel)
               0: txt[p] = cpfv_pkg::CH_DOT;
               1: txt[p] = cpfv_pkg::CH_DASH;
               2: txt[p] = 8'(cpfv_pkg::CH_ZERO + $urandom_range(0, 9));
               default: txt[p] = 8'($urandom_range(0, 255));
            endcase
         end
      end else if (kind < 86) begin
         if ($urandom_range(0, 1) == 0) begin
            len = $urandom_range(1, cpfv_pkg::CPF_LEN - 1);
            while (txt.size() > len) void'(txt.pop_back());
         end else begin
            repeat ($urandom_range(1, 6)) begin
               if ($urandom_range(0, 1) == 0)
                  txt.push_back(8'(cpfv_pkg::CH_ZERO + $urandom_range(0, 9)));
               else
                  txt.push_back(8'($urandom_range(0, 255)));
            end
         end
      end else begin
         txt.delete();
         len = $urandom_range(1, 18);
         repeat (len) txt.push_back(8'($urandom_range(0, 255)));
      end
   endtask

   // sender: bursts of items separated by random gaps
   int burst_left = 1;
   int gap_left = 0;

   always @(posedge clock) begin : sender
      char_item_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (gap_left != 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (char_feed.size() != 0) begin
            nxt = char_feed.pop_front();
            offered <= nxt;
            req_char_code <= nxt.ch;
            req_end_of_string <= nxt.last;
            req_valid <= 1'b1;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 30);
               gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: stall pattern changes when a random mode timer runs out, one long hold-off
   int  stall_mode = 0;
   int  mode_timer = 0;
   int  hold_left = 0;
   bit  hold_done = 1'b0;
   bit  stall_phase = 1'b0;

   always @(posedge clock) begin : receiver
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (!hold_done && results_seen == HOLD_AFTER) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         if (mode_timer == 0) begin
            mode_timer <= $urandom_range(20, 80);
            stall_mode <= $urandom_range(0, 3);
         end else begin
            mode_timer <= mode_timer - 1;
         end
         stall_phase <= !stall_phase;
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= ($urandom_range(0, 3) != 0);
            default: rsp_stall <= stall_phase;
         endcase
      end
   end

   always @(posedge clock) begin : scoreboard
      cpfv_pkg::err_type     code;
      cpfv_pkg::verdict_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            items_accepted <= items_accepted + 1;
            if (cpf_scan_char(req_char_code, req_end_of_string, code)) begin
               if (offered.typed) code = offered.verdict;
               want.is_valid = (code == cpfv_pkg::ERR_NONE);
               want.error_code = code;
               pending_verdicts.push_back(want);
            end
         end
         if (rsp_valid && !rsp_stall) begin
            results_seen <= results_seen + 1;
            if (pending_verdicts.size() == 0) begin
               $error("result item with no verdict pending");
               failed = 1'b1;
            end else begin
               want = pending_verdicts.pop_front();
               if (rsp_is_valid !== want.is_valid) begin
                  $error("is_valid: expected %0d, got %0d", want.is_valid, rsp_is_valid);
                  failed = 1'b1;
               end
               if (rsp_error_code !== want.error_code) begin
                  $error("error_code: expected %0d, got %0d", want.error_code,
                         rsp_error_code);
                  failed = 1'b1;
               end
            end
         end
      end
   end

   initial begin
      dir_row_type directed_rows[3];
      logic [7:0]  txt[$];
      int          random_start;
      directed_rows[0] = '{"\377", 1'b1, cpfv_pkg::ERR_LENGTH};
      directed_rows[1] = '{"529.982.247-25", 1'b1, cpfv_pkg::ERR_NONE};
      directed_rows[2] = '{"0.-/:\200a", 1'b1, cpfv_pkg::ERR_LENGTH};
      foreach (directed_rows[r]) begin
         txt.delete();
         for (int i = 0; i < directed_rows[r].text.len(); i++)
            txt.push_back(directed_rows[r].text[i]);
         feed_string(txt, directed_rows[r].typed, directed_rows[r].verdict);
      end
      random_start = char_feed.size();
      while (char_feed.size() - random_start < RANDOM_ITEMS) begin
         make_random_string(txt);
         feed_string(txt, 1'b0, cpfv_pkg::ERR_NONE);
      end
      feed_total = char_feed.size();

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      while (items_accepted != feed_total || pending_verdicts.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_verdicts.size() != 0) begin
         $error("%0d verdicts never arrived", pending_verdicts.size());
         failed = 1'b1;
      end
      if (!failed) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule
`default_nettype wire
